// ===== rtl/rcpwq_pkg.sv =====
// rcpwq_pkg: shared types, constants and helpers of the RC pulse width qualifier.
// Used by every module under rtl/ but rcpwq_checker; has no dependencies of its own.

package rcpwq_pkg;

    localparam int NUM_CH = 3;

    // Calibration and limit defaults after reset
    localparam logic [15:0] MIN_RESET    = 16'd6600;
    localparam logic [15:0] SPAN_RESET   = 16'd4800;   // 11400 - 6600
    localparam logic [31:0] PLIMIT_RESET = 32'd1000000;
    localparam logic [15:0] PWM_RESET    = 16'd4500;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_CH0      = 3'd0;
    localparam logic [2:0] CFG_MIN_CH1      = 3'd1;
    localparam logic [2:0] CFG_MIN_CH2      = 3'd2;
    localparam logic [2:0] CFG_SPAN_CH0     = 3'd3;
    localparam logic [2:0] CFG_SPAN_CH1     = 3'd4;
    localparam logic [2:0] CFG_SPAN_CH2     = 3'd5;
    localparam logic [2:0] CFG_PERIOD_LIMIT = 3'd6;
    localparam logic [2:0] CFG_PWM_PERIOD   = 3'd7;

    // Channel codes
    localparam logic [1:0] CH0 = 2'd0;
    localparam logic [1:0] CH1 = 2'd1;
    localparam logic [1:0] CH2 = 2'd2;
    localparam logic [1:0] CH_BAD = 2'd3;

    // Reciprocal constants for division by ten
    localparam logic [31:0] RECIP10_32 = 32'hCCCC_CCCD;   // exact with >> 35
    localparam logic [19:0] RECIP10_17 = 20'hCCCCD;       // exact with >> 23

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_CLASS
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_DONE
    } t_back_state;

    // One classified capture on its way to the duty calculation
    typedef struct packed {
        logic [1:0]  channel;
        logic [16:0] width;
        logic [15:0] min_val;
        logic [15:0] span;
        logic        out_of_range;
        logic [15:0] error_count;
        logic [31:0] longest_period;
    } t_qentry;

    // Floor of a 17-bit value divided by ten
    function automatic logic [13:0] div10_17(input logic [16:0] x);
        logic [36:0] p;
        p = {20'd0, x} * {17'd0, RECIP10_17};
        return p[36:23];
    endfunction

endpackage

// ===== rtl/rc_pulse_width_qualifier_unit.sv =====
// rc_pulse_width_qualifier_unit: top level of the RC pulse width qualifier.
// Holds the configuration registers; instantiates rcpwq_front, rcpwq_queue and
// rcpwq_back; depends on rcpwq_pkg.
//
// Usage:
//   Input side looks like a queue: drive i_high_ticks / i_period_ticks and
//   raise push; a beat is taken on a clock edge with push high and full low.
//   Captures are assigned to channels 0, 1, 2 in rotation from reset.
//   Result side also looks like a queue: while empty is low the oldest result
//   sits on the o_* ports; pop with empty low takes that beat.
//   Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we; only
//   while the block is idle. Register order: min ch0..ch2, span ch0..ch2,
//   period limit, PWM period.
//
// Timing:
//   The front handles one capture at a time: latch, reciprocal multiply, classify;
//   full stays high until the classified capture enters the queue. The back pops
//   an entry, multiplies, runs the one-bit-per-cycle restoring divider when a
//   division is needed, and loads the result register; it pops the next entry
//   only after that load.
//   When the receiver stalls, the result register holds, the back finishes its
//   current item, the queue fills, and then full rises on the input side.
//   Reset clears the channel rotation, error total, longest period, the queue
//   and the result register, and restores calibration defaults.

module rc_pulse_width_qualifier_unit #(
    parameter int QDEPTH = rcpwq_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_high_ticks,
    input  logic [31:0] i_period_ticks,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_channel,
    output logic [16:0] o_width,
    output logic [15:0] o_duty,
    output logic        o_out_of_range,
    output logic [15:0] o_error_count,
    output logic [31:0] o_longest_period,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [rcpwq_pkg::NUM_CH-1:0][15:0] r_min;
    logic [rcpwq_pkg::NUM_CH-1:0][15:0] r_span;
    logic [31:0] r_period_limit;
    logic [15:0] r_pwm_period;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    rcpwq_pkg::t_qentry q_in;
    rcpwq_pkg::t_qentry q_out;

    // Configuration registers: indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min          <= {rcpwq_pkg::NUM_CH{rcpwq_pkg::MIN_RESET}};
            r_span         <= {rcpwq_pkg::NUM_CH{rcpwq_pkg::SPAN_RESET}};
            r_period_limit <= rcpwq_pkg::PLIMIT_RESET;
            r_pwm_period   <= rcpwq_pkg::PWM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcpwq_pkg::CFG_MIN_CH0:      r_min[0]       <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_MIN_CH1:      r_min[1]       <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_MIN_CH2:      r_min[2]       <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_SPAN_CH0:     r_span[0]      <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_SPAN_CH1:     r_span[1]      <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_SPAN_CH2:     r_span[2]      <= i_cfg_data[15:0];
                rcpwq_pkg::CFG_PERIOD_LIMIT: r_period_limit <= i_cfg_data;
                rcpwq_pkg::CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data[15:0];
                default:                     r_pwm_period   <= r_pwm_period;
            endcase
        end
    end

    // Front: accept, pick channel, qualify width, advance totals
    rcpwq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_high_ticks   (i_high_ticks),
        .i_period_ticks (i_period_ticks),
        .i_min          (r_min),
        .i_span         (r_span),
        .i_period_limit (r_period_limit),
        .o_q_push       (q_push),
        .i_q_full       (q_full),
        .o_q_entry      (q_in)
    );

    // Decouple classification from the slow duty divider
    rcpwq_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty)
    );

    // Back: duty value and result register
    rcpwq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_entry        (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_pwm_period     (r_pwm_period),
        .empty            (empty),
        .pop              (pop),
        .o_channel        (o_channel),
        .o_width          (o_width),
        .o_duty           (o_duty),
        .o_out_of_range   (o_out_of_range),
        .o_error_count    (o_error_count),
        .o_longest_period (o_longest_period)
    );

endmodule

// ===== rtl/rcpwq_front.sv =====
// rcpwq_front: accepts captures, picks the channel, qualifies the width and keeps
// the error and longest-period totals. Depends on rcpwq_pkg.

module rcpwq_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [31:0]              i_high_ticks,
    input  logic [31:0]              i_period_ticks,
    input  logic [rcpwq_pkg::NUM_CH-1:0][15:0] i_min,
    input  logic [rcpwq_pkg::NUM_CH-1:0][15:0] i_span,
    input  logic [31:0]              i_period_limit,
    output logic                     o_q_push,
    input  logic                     i_q_full,
    output rcpwq_pkg::t_qentry       o_q_entry
);

    rcpwq_pkg::t_front_state r_state, n_state;

    logic [1:0]  r_ch_idx;
    logic [1:0]  r_ch;
    logic [31:0] r_high;
    logic [31:0] r_period;
    logic [15:0] r_min;
    logic [15:0] r_span;
    logic [28:0] r_raw;
    logic [17:0] r_too_much;
    logic [15:0] r_too_little;
    logic [16:0] r_low_guard;
    logic [16:0] r_high_guard;
    logic [16:0] r_mid;
    logic [15:0] r_err;
    logic [31:0] r_longest;

    logic [1:0]  cur_ch;
    logic [15:0] sel_min;
    logic [15:0] sel_span;
    logic [63:0] raw_prod;
    logic [16:0] maxv;
    logic [13:0] max10;
    logic [13:0] min10;
    logic [17:0] mid_sum;
    logic        oor;
    logic [16:0] width;
    logic [15:0] n_err;
    logic [31:0] n_longest;
    logic        accept;

    // A stray channel code of three is served as channel zero
    always_comb begin
        cur_ch = (r_ch_idx == rcpwq_pkg::CH_BAD) ? rcpwq_pkg::CH0 : r_ch_idx;
        case (cur_ch)
            rcpwq_pkg::CH1: begin
                sel_min  = i_min[1];
                sel_span = i_span[1];
            end
            rcpwq_pkg::CH2: begin
                sel_min  = i_min[2];
                sel_span = i_span[2];
            end
            default: begin
                sel_min  = i_min[0];
                sel_span = i_span[0];
            end
        endcase
    end

    // Thresholds from the calibration of the latched channel
    always_comb begin
        raw_prod = {32'd0, r_high} * {32'd0, rcpwq_pkg::RECIP10_32};
        maxv     = {1'b0, r_min} + {1'b0, r_span};
        max10    = rcpwq_pkg::div10_17(maxv);
        min10    = rcpwq_pkg::div10_17({1'b0, r_min});
        mid_sum  = {2'b00, r_min} + {1'b0, maxv};
    end

    // Classification of the raw width
    always_comb begin
        oor = ({11'd0, r_too_much} < r_raw) || (r_raw < {13'd0, r_too_little});
        if (oor) begin
            width = r_mid;
        end else if (r_raw < {12'd0, r_low_guard}) begin
            width = r_low_guard;
        end else if (r_raw > {12'd0, r_high_guard}) begin
            width = r_high_guard;
        end else begin
            width = r_raw[16:0];
        end
        n_err = (oor && (r_err != 16'hFFFF)) ? r_err + 16'd1 : r_err;
        n_longest = ((r_period > r_longest) && (r_longest < i_period_limit)) ?
                    r_period : r_longest;
    end

    always_comb begin
        o_q_entry.channel        = r_ch;
        o_q_entry.width          = width;
        o_q_entry.min_val        = r_min;
        o_q_entry.span           = r_span;
        o_q_entry.out_of_range   = oor;
        o_q_entry.error_count    = n_err;
        o_q_entry.longest_period = n_longest;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcpwq_pkg::F_IDLE:  if (push) n_state = rcpwq_pkg::F_MUL;
            rcpwq_pkg::F_MUL:   n_state = rcpwq_pkg::F_CLASS;
            rcpwq_pkg::F_CLASS: if (!i_q_full) n_state = rcpwq_pkg::F_IDLE;
            default:            n_state = rcpwq_pkg::F_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        full     = 1'b1;
        o_q_push = 1'b0;
        case (r_state)
            rcpwq_pkg::F_IDLE:  full = 1'b0;
            rcpwq_pkg::F_CLASS: o_q_push = !i_q_full;
            default:            full = 1'b1;
        endcase
    end

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rcpwq_pkg::F_IDLE;
            r_ch_idx  <= rcpwq_pkg::CH0;
            r_err     <= '0;
            r_longest <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_push) begin
                r_err     <= n_err;
                r_longest <= n_longest;
                r_ch_idx  <= (r_ch == rcpwq_pkg::CH2) ? rcpwq_pkg::CH0 : r_ch + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_high   <= i_high_ticks;
            r_period <= i_period_ticks;
            r_ch     <= cur_ch;
            r_min    <= sel_min;
            r_span   <= sel_span;
        end
        if (r_state == rcpwq_pkg::F_MUL) begin
            r_raw        <= raw_prod[63:35];
            r_too_much   <= {1'b0, maxv} + {4'd0, max10};
            r_too_little <= r_min - {2'd0, min10};
            r_low_guard  <= {1'b0, r_min} + {4'd0, min10[13:1]};
            r_high_guard <= maxv - {4'd0, max10[13:1]};
            r_mid        <= mid_sum[17:1];
        end
    end

endmodule

// ===== rtl/rcpwq_queue.sv =====
// rcpwq_queue: short queue of classified captures between front and back.
// Depends on rcpwq_pkg for the entry type.

module rcpwq_queue #(
    parameter int DEPTH = rcpwq_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rcpwq_pkg::t_qentry i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output rcpwq_pkg::t_qentry o_entry,
    output logic               o_empty
);

    localparam int AW = $clog2(DEPTH);

    rcpwq_pkg::t_qentry r_mem [DEPTH];
    logic [AW:0] r_wptr;
    logic [AW:0] r_rptr;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[AW] != r_rptr[AW]) && (r_wptr[AW-1:0] == r_rptr[AW-1:0]);
    assign o_entry = r_mem[r_rptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push && !o_full) r_wptr <= r_wptr + 1'b1;
            if (i_pop && !o_empty) r_rptr <= r_rptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wptr[AW-1:0]] <= i_entry;
    end

endmodule

// ===== rtl/rcpwq_back.sv =====
// rcpwq_back: duty calculation with a bit-serial divider and the result register.
// Depends on rcpwq_pkg.

module rcpwq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcpwq_pkg::t_qentry i_q_entry,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [15:0]        i_pwm_period,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_channel,
    output logic [16:0]        o_width,
    output logic [15:0]        o_duty,
    output logic               o_out_of_range,
    output logic [15:0]        o_error_count,
    output logic [31:0]        o_longest_period
);

    rcpwq_pkg::t_back_state r_state, n_state;

    rcpwq_pkg::t_qentry r_ent;
    logic [15:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_cnt;
    logic        r_out_valid;
    rcpwq_pkg::t_qentry r_out;
    logic [15:0] r_out_duty;

    logic [16:0] diff;
    logic        duty_zero;
    logic        duty_sat;
    logic [31:0] prod;
    logic [16:0] trial;
    logic        qbit;
    logic [16:0] trial_sub;
    logic        out_load;

    always_comb begin
        diff      = r_ent.width - {1'b0, r_ent.min_val};
        duty_zero = (r_ent.span == 16'd0) || (r_ent.width <= {1'b0, r_ent.min_val});
        duty_sat  = (diff >= {1'b0, r_ent.span});
        prod      = {16'd0, diff[15:0]} * {16'd0, i_pwm_period};
        // Restoring step: remainder stays below span, so it fits in 16 bits
        trial     = {r_rem, r_quo[15]};
        trial_sub = trial - {1'b0, r_ent.span};
        qbit      = (trial >= {1'b0, r_ent.span});
    end

    assign out_load = (r_state == rcpwq_pkg::B_DONE) && (!r_out_valid || pop);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcpwq_pkg::B_IDLE: if (!i_q_empty) n_state = rcpwq_pkg::B_MUL;
            rcpwq_pkg::B_MUL: begin
                if (duty_zero || duty_sat) n_state = rcpwq_pkg::B_DONE;
                else                       n_state = rcpwq_pkg::B_DIV;
            end
            rcpwq_pkg::B_DIV:  if (r_cnt == 4'hF) n_state = rcpwq_pkg::B_DONE;
            rcpwq_pkg::B_DONE: if (!r_out_valid || pop) n_state = rcpwq_pkg::B_IDLE;
            default:           n_state = rcpwq_pkg::B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop = 1'b0;
        case (r_state)
            rcpwq_pkg::B_IDLE: o_q_pop = !i_q_empty;
            default:           o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcpwq_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)             r_out_valid <= 1'b1;
            else if (pop && !empty)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_ent <= i_q_entry;
        case (r_state)
            rcpwq_pkg::B_MUL: begin
                r_cnt <= '0;
                if (duty_zero) begin
                    r_quo <= '0;
                end else if (duty_sat) begin
                    r_quo <= i_pwm_period;
                end else begin
                    r_rem <= prod[31:16];
                    r_quo <= prod[15:0];
                end
            end
            rcpwq_pkg::B_DIV: begin
                r_rem <= qbit ? trial_sub[15:0] : trial[15:0];
                r_quo <= {r_quo[14:0], qbit};
                r_cnt <= r_cnt + 4'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
        if (out_load) begin
            r_out      <= r_ent;
            r_out_duty <= r_quo;
        end
    end

    assign empty            = !r_out_valid;
    assign o_channel        = r_out.channel;
    assign o_width          = r_out.width;
    assign o_duty           = r_out_duty;
    assign o_out_of_range   = r_out.out_of_range;
    assign o_error_count    = r_out.error_count;
    assign o_longest_period = r_out.longest_period;

endmodule

// ===== rtl/rcpwq_checker.sv =====
// rcpwq_checker: port-level assertions for rc_pulse_width_qualifier_unit,
// attached by the bind at the end of this file. No package dependency.

module rcpwq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_channel,
    input logic [16:0] o_width,
    input logic [15:0] o_error_count
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // Reset leaves the input side open
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    // Only channels zero to two ever appear
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_channel != 2'd3))
        else $error("channel code three on result");

    // A waiting result stays, with its width and error count, until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_width) && $stable(o_error_count)))
        else $error("waiting result changed");

endmodule

bind rc_pulse_width_qualifier_unit rcpwq_checker u_rcpwq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_channel     (o_channel),
    .o_width       (o_width),
    .o_error_count (o_error_count)
);
